@@ rtl/fpl_pkg.sv @@
`default_nettype none
package fpl_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_SELECT  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_HOLD     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_WAIT   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FINISH_WAIT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_CLOCKS    = 3'd4;

   localparam logic [7:0] RESET_HOLD_DEFAULT   = 8'd2;
   localparam logic [7:0] RELEASE_WAIT_DEFAULT = 8'd5;
   localparam logic [7:0] FINISH_WAIT_DEFAULT  = 8'd5;
   localparam logic [6:0] INIT_CLOCKS_DEFAULT  = 7'd40;
   localparam logic [6:0] INIT_CLOCKS_MAX      = 7'd64;
   localparam logic [6:0] INIT_CLOCKS_MIN      = 7'd1;
   localparam logic [2:0] BIT_LAST             = 3'd7;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_DATA   = 2'd1,
      CMD_FINISH = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LOAD = 2'd1,
      PH_HELD = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_START = 3'd1,
      ST_DATA  = 3'd2,
      ST_DONE  = 3'd3,
      ST_ORDER = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      JOB_START  = 2'd0,
      JOB_DATA   = 2'd1,
      JOB_FINISH = 2'd2,
      JOB_REJECT = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         fail;
      logic [7:0]   data_byte;
      logic [2:0]   err_pos;
      logic         ldb;
      logic         ncfg;
   } job_type;

   typedef struct packed {
      logic       target_select;
      logic [7:0] reset_hold_cycles;
      logic [7:0] release_wait_cycles;
      logic [7:0] finish_wait_cycles;
      logic [6:0] init_clocks;
   } cfg_type;

endpackage
`default_nettype wire

@@ rtl/fpl_req_if.sv @@
`default_nettype none
interface fpl_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;
   logic [7:0] nstatus_samples;
   logic       conf_done_level;

   modport source (output valid, output cmd, output data_byte, output nstatus_samples,
                   output conf_done_level, input ready);
   modport sink (input valid, input cmd, input data_byte, input nstatus_samples,
                 input conf_done_level, output ready);
endinterface
`default_nettype wire

@@ rtl/fpl_rsp_if.sv @@
`default_nettype none
interface fpl_rsp_if #(
   parameter int IDX_BITS = 24
);
   logic                valid;
   logic                ready;
   logic                target;
   logic                nconfig_level;
   logic                clock_pulse;
   logic                data0_level;
   logic [7:0]          hold_cycles;
   logic [2:0]          status;
   logic [IDX_BITS-1:0] error_byte;
   logic [2:0]          error_bit;
   logic                last;

   modport source (output valid, output target, output nconfig_level, output clock_pulse,
                   output data0_level, output hold_cycles, output status,
                   output error_byte, output error_bit, output last, input ready);
   modport sink (input valid, input target, input nconfig_level, input clock_pulse,
                 input data0_level, input hold_cycles, input status,
                 input error_byte, input error_bit, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/fpga_passive_serial_loader_unit.sv @@
// channel    dir  handshake        payload
// req_chan   in   valid/ready      cmd, data_byte, nstatus_samples, conf_done_level
// rsp_chan   out  valid/ready      target .. last, one pin step per beat
// csr_*      in   write enable     csr_index, csr_write_data
//
// the back end issues one result beat per cycle while the queue holds a job and rsp is
// not stalled; a data byte takes 1 to 8 beats, start 2, finish 1 to 64 (init_clocks), others 1
// the front end takes a command per cycle while the two-entry queue has room
// synchronous reset clears phase, byte index, queue and output valid
// rsp stalls hold the output register; the front keeps filling the queue
`default_nettype none
module fpga_passive_serial_loader_unit
   import fpl_pkg::*;
#(
   parameter int BYTE_INDEX_BITS = 24
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      csr_write_enable,
   input  wire [CSR_INDEX_BITS-1:0] csr_index,
   input  wire [CSR_DATA_BITS-1:0]  csr_write_data,
   fpl_req_if.sink                  req_chan,
   fpl_rsp_if.source                rsp_chan
);

   cfg_type                    cfg_ff;
   logic                       q_push, q_pop, q_empty, q_full;
   job_type                    push_job, head_job;
   logic [BYTE_INDEX_BITS-1:0] push_idx, head_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_select       <= 1'b0;
         cfg_ff.reset_hold_cycles   <= RESET_HOLD_DEFAULT;
         cfg_ff.release_wait_cycles <= RELEASE_WAIT_DEFAULT;
         cfg_ff.finish_wait_cycles  <= FINISH_WAIT_DEFAULT;
         cfg_ff.init_clocks         <= INIT_CLOCKS_DEFAULT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TARGET_SELECT: cfg_ff.target_select       <= csr_write_data[0];
            CSR_RESET_HOLD:    cfg_ff.reset_hold_cycles   <= csr_write_data;
            CSR_RELEASE_WAIT:  cfg_ff.release_wait_cycles <= csr_write_data;
            CSR_FINISH_WAIT:   cfg_ff.finish_wait_cycles  <= csr_write_data;
            CSR_INIT_CLOCKS:   cfg_ff.init_clocks         <= csr_write_data[6:0];
            default: begin
            end
         endcase
      end
   end

   fpl_front #(
      .IDX_BITS (BYTE_INDEX_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job),
      .q_idx    (push_idx)
   );

   fpl_queue #(
      .IDX_BITS (BYTE_INDEX_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .push_idx (push_idx),
      .pop      (q_pop),
      .head_job (head_job),
      .head_idx (head_idx),
      .empty    (q_empty),
      .full     (q_full)
   );

   fpl_back #(
      .IDX_BITS (BYTE_INDEX_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .job      (head_job),
      .job_idx  (head_idx),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   // a data error beat is a pulse and ends its command
   a_data_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_DATA |-> rsp_chan.clock_pulse && rsp_chan.last)
      else $error("data error beat not a closing pulse");

   // every error beat ends its command
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != ST_OK |-> rsp_chan.last)
      else $error("error beat not last");

   // error position only on data errors
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != ST_DATA
      |-> rsp_chan.error_bit == 3'd0 && rsp_chan.error_byte == '0)
      else $error("error position outside data error");

   // nothing is popped from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

endmodule
`default_nettype wire

@@ rtl/fpl_front.sv @@
`default_nettype none
module fpl_front
   import fpl_pkg::*;
#(
   parameter int IDX_BITS = 24
) (
   input  wire                 clock,
   input  wire                 reset,
   fpl_req_if.sink             req_chan,
   input  wire                 q_full,
   output logic                q_push,
   output job_type             q_job,
   output logic [IDX_BITS-1:0] q_idx
);

   phase_type           phase_ff, phase_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                ldb_ff, ldb_in;
   logic [2:0]          zero_pos;
   logic                ns_err;
   logic [2:0]          end_pos;

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;
   assign q_idx          = idx_ff;

   // first low nstatus sample
   always_comb begin
      zero_pos = BIT_LAST;
      for (int i = 7; i >= 0; i--) begin
         if (!req_chan.nstatus_samples[i]) begin
            zero_pos = 3'(i);
         end
      end
      ns_err  = !(&req_chan.nstatus_samples);
      end_pos = ns_err ? zero_pos : BIT_LAST;
   end

   always_comb begin
      phase_in        = phase_ff;
      idx_in          = idx_ff;
      ldb_in          = ldb_ff;
      q_job.kind      = JOB_REJECT;
      q_job.fail      = 1'b0;
      q_job.data_byte = req_chan.data_byte;
      q_job.err_pos   = zero_pos;
      q_job.ldb       = ldb_ff;
      q_job.ncfg      = (phase_ff != PH_HELD);
      priority if (req_chan.cmd == CMD_START) begin
         q_job.kind = JOB_START;
         q_job.fail = req_chan.nstatus_samples[0];
         if (req_chan.nstatus_samples[0]) begin
            phase_in = PH_HELD;
         end else begin
            phase_in = PH_LOAD;
            idx_in   = '0;
         end
      end else if (req_chan.cmd == CMD_DATA && phase_ff == PH_LOAD) begin
         q_job.kind = JOB_DATA;
         q_job.fail = ns_err;
         ldb_in     = req_chan.data_byte[end_pos];
         if (ns_err) begin
            phase_in = PH_IDLE;
         end else if (!(&idx_ff)) begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (req_chan.cmd == CMD_FINISH && phase_ff == PH_LOAD) begin
         q_job.kind = JOB_FINISH;
         q_job.fail = !req_chan.conf_done_level;
         phase_in   = PH_IDLE;
      end else begin
         q_job.kind = JOB_REJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= '0;
         ldb_ff   <= 1'b0;
      end else if (q_push) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         ldb_ff   <= ldb_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/fpl_queue.sv @@
`default_nettype none
module fpl_queue
   import fpl_pkg::*;
#(
   parameter int IDX_BITS = 24
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  job_type             push_job,
   input  wire [IDX_BITS-1:0]  push_idx,
   input  wire                 pop,
   output job_type             head_job,
   output logic [IDX_BITS-1:0] head_idx,
   output logic                empty,
   output logic                full
);

   job_type             job_ff [2];
   logic [IDX_BITS-1:0] idx_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign head_job = job_ff[rd_ptr_ff];
   assign head_idx = idx_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ptr_ff] <= push_job;
         idx_ff[wr_ptr_ff] <= push_idx;
      end
   end

endmodule
`default_nettype wire

@@ rtl/fpl_back.sv @@
`default_nettype none
module fpl_back
   import fpl_pkg::*;
#(
   parameter int IDX_BITS = 24
) (
   input  wire                 clock,
   input  wire                 reset,
   input  cfg_type             cfg,
   input  job_type             job,
   input  wire [IDX_BITS-1:0]  job_idx,
   input  wire                 q_empty,
   output logic                q_pop,
   fpl_rsp_if.source           rsp_chan
);

   logic [5:0]          k_ff, k_in;
   logic                valid_ff, valid_in;
   logic                target_ff, ncfg_ff, clk_ff, d0_ff, last_ff;
   logic [7:0]          hold_ff;
   status_type          st_ff;
   logic [IDX_BITS-1:0] eb_ff;
   logic [2:0]          ebit_ff;

   logic                ncfg_c, clk_c, d0_c, last_c;
   logic [7:0]          hold_c;
   status_type          st_c;
   logic [IDX_BITS-1:0] eb_c;
   logic [2:0]          ebit_c;
   logic [6:0]          n_clamp, n_m1;
   logic                advance, fire;

   assign advance = !valid_ff || rsp_chan.ready;
   assign fire    = advance && !q_empty;
   assign q_pop   = fire && last_c;

   always_comb begin
      if (cfg.init_clocks < INIT_CLOCKS_MIN) begin
         n_clamp = INIT_CLOCKS_MIN;
      end else if (cfg.init_clocks > INIT_CLOCKS_MAX) begin
         n_clamp = INIT_CLOCKS_MAX;
      end else begin
         n_clamp = cfg.init_clocks;
      end
      n_m1 = n_clamp - 7'd1;
   end

   always_comb begin
      ncfg_c = 1'b1;
      clk_c  = 1'b0;
      d0_c   = job.ldb;
      hold_c = 8'd0;
      st_c   = ST_OK;
      eb_c   = '0;
      ebit_c = 3'd0;
      last_c = 1'b1;
      unique case (job.kind)
         JOB_START: begin
            ncfg_c = 1'b0;
            if (!k_ff[0]) begin
               hold_c = cfg.reset_hold_cycles;
               last_c = 1'b0;
            end else if (job.fail) begin
               st_c = ST_START;
            end else begin
               ncfg_c = 1'b1;
               hold_c = cfg.release_wait_cycles;
            end
         end
         JOB_DATA: begin
            clk_c = 1'b1;
            d0_c  = job.data_byte[k_ff[2:0]];
            if (job.fail && k_ff[2:0] == job.err_pos) begin
               st_c   = ST_DATA;
               eb_c   = job_idx;
               ebit_c = k_ff[2:0];
            end else if (k_ff[2:0] == BIT_LAST) begin
               hold_c = cfg.finish_wait_cycles;
            end else begin
               last_c = 1'b0;
            end
         end
         JOB_FINISH: begin
            if (job.fail) begin
               st_c = ST_DONE;
            end else begin
               clk_c  = 1'b1;
               last_c = (k_ff == n_m1[5:0]);
            end
         end
         JOB_REJECT: begin
            ncfg_c = job.ncfg;
            st_c   = ST_ORDER;
         end
         default: begin
            st_c = ST_ORDER;
         end
      endcase
   end

   always_comb begin
      valid_in = advance ? !q_empty : valid_ff;
      if (q_pop) begin
         k_in = 6'd0;
      end else if (fire) begin
         k_in = k_ff + 6'd1;
      end else begin
         k_in = k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         k_ff     <= 6'd0;
      end else begin
         valid_ff <= valid_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         target_ff <= cfg.target_select;
         ncfg_ff   <= ncfg_c;
         clk_ff    <= clk_c;
         d0_ff     <= d0_c;
         hold_ff   <= hold_c;
         st_ff     <= st_c;
         eb_ff     <= eb_c;
         ebit_ff   <= ebit_c;
         last_ff   <= last_c;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.target        = target_ff;
   assign rsp_chan.nconfig_level = ncfg_ff;
   assign rsp_chan.clock_pulse   = clk_ff;
   assign rsp_chan.data0_level   = d0_ff;
   assign rsp_chan.hold_cycles   = hold_ff;
   assign rsp_chan.status        = st_ff;
   assign rsp_chan.error_byte    = eb_ff;
   assign rsp_chan.error_bit     = ebit_ff;
   assign rsp_chan.last          = last_ff;

endmodule
`default_nettype wire
